### hw/rtl/integer_ascii_formatter_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer ASCII formatter
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INTEGER_ASCII_FORMATTER_TOP_MACROS_SVH
`define INTEGER_ASCII_FORMATTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define IAF_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iaf assertion failed");
// Next-cycle implication, disabled during reset
`define IAF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iaf assertion failed");
`else
`define IAF_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define IAF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/iaf_pkg.sv
// ----------------------------------------------------------------------------
// iaf_pkg
// Shared types, character codes and sizing helpers for the integer ASCII
// formatter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iaf_pkg;

  // Default sizes
  localparam int VALUE_BITS_DEF   = 32;
  localparam int MAX_WIDTH_DEF    = 32;
  localparam int FIELD_WIDTH_BITS = 6;

  // ASCII codes
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_X     = 8'h78;

  // Digit value to character, upper-case hex
  localparam logic [7:0] HEX_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_PAD,
    ST_LEAD,
    ST_PREFIX,
    ST_XMARK,
    ST_ZEROS,
    ST_DIGITS
  } state_t;

  // Which character the output register takes
  typedef enum logic [2:0] {
    CH_PAD_SPACE,
    CH_PAD_ZERO,
    CH_SIGN,
    CH_X,
    CH_DIGIT
  } char_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    logic      conv_step;
    logic      norm_step;
    logic      pad_load;
    logic      emit;
    char_sel_t sel;
    logic      last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic conv_done;
    logic norm_done;
    logic pad_empty;
    logic hex;
    logic neg;
    logic zpad;
    logic last_digit;
    logic out_free;
  } sts_t;

  // Decimal digits of the largest unsigned value of the given width
  function automatic int dec_digits(input int bits);
    return ((bits * 1233) >> 12) + 1;
  endfunction

  // Digit slots that hold either the decimal or the hex form
  function automatic int digit_slots(input int bits);
    int nhex;
    int ndec;
    nhex = (bits + 3) >> 2;
    ndec = dec_digits(bits);
    return (ndec > nhex) ? ndec : nhex;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/iaf_in_if.sv
// ----------------------------------------------------------------------------
// iaf_in_if
// Input channel: one value with its format settings, valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface iaf_in_if #(
  parameter int VALUE_BITS = iaf_pkg::VALUE_BITS_DEF
) ();
  logic                                  valid;
  logic                                  ready;
  logic [VALUE_BITS-1:0]                 value;
  logic                                  opcode;
  logic [iaf_pkg::FIELD_WIDTH_BITS-1:0]  field_width;
  logic                                  pad_zero;

  modport source (output valid, value, opcode, field_width, pad_zero, input ready);
  modport sink   (input valid, value, opcode, field_width, pad_zero, output ready);
endinterface

`default_nettype wire

### hw/rtl/iaf_out_if.sv
// ----------------------------------------------------------------------------
// iaf_out_if
// Output channel: one ASCII character and its last flag per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface iaf_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       last;

  modport source (output valid, char_out, last, input ready);
  modport sink   (input valid, char_out, last, output ready);
endinterface

`default_nettype wire

### hw/rtl/iaf_dp.sv
// ----------------------------------------------------------------------------
// iaf_dp
// Datapath: magnitude, shift-add-3 binary to BCD, digit normalisation, pad
// count and the output character register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "integer_ascii_formatter_top_macros.svh"

module iaf_dp #(
  parameter int VALUE_BITS = iaf_pkg::VALUE_BITS_DEF,
  parameter int MAX_WIDTH  = iaf_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic [VALUE_BITS-1:0]                value,
  input  wire logic                                 opcode,
  input  wire logic [iaf_pkg::FIELD_WIDTH_BITS-1:0] field_width,
  input  wire logic                                 pad_zero,
  input  wire iaf_pkg::cmd_t                        cmd,
  output iaf_pkg::sts_t                             sts,
  iaf_out_if.source                                 dout
);

  localparam int NDIG = iaf_pkg::digit_slots(VALUE_BITS);
  localparam int DW   = NDIG * 4;
  localparam int CNTW = $clog2(NDIG + 1);
  localparam int BW   = $clog2(VALUE_BITS + 1);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int SW   = $clog2(MAX_WIDTH + NDIG + 3);

  logic [VALUE_BITS-1:0] bin;
  logic [DW-1:0]         dig;
  logic [BW-1:0]         bits;
  logic [CNTW-1:0]       count;
  logic [WW-1:0]         width_r;
  logic [WW-1:0]         pad;
  logic                  hex_r;
  logic                  neg_r;
  logic                  zpad_r;
  logic                  out_valid;
  logic [7:0]            out_char;
  logic                  out_last;

  logic                  neg_in;
  logic [VALUE_BITS-1:0] mag;
  logic [WW-1:0]         w_sat;
  logic [DW-1:0]         adj;
  logic [SW-1:0]         total;
  logic [SW-1:0]         width_ext;
  logic [7:0]            char_next;
  logic [3:0]            top_digit;
  logic                  out_free;

  // Sign and magnitude of the incoming value
  assign neg_in = !opcode && value[VALUE_BITS-1];
  assign mag    = neg_in ? (~value + 1'b1) : value;

  // Saturate the field width
  always_comb begin
    if (int'(field_width) > MAX_WIDTH) begin
      w_sat = WW'(MAX_WIDTH);
    end else begin
      w_sat = WW'(field_width);
    end
  end

  // Add 3 to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (dig[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = dig[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = dig[i*4 +: 4];
      end
    end
  end

  // Characters taken by the number besides the pad
  always_comb begin
    width_ext = SW'(width_r);
    if (hex_r) begin
      total = SW'(count) + SW'(2);
    end else if (neg_r) begin
      total = SW'(count) + SW'(1);
    end else begin
      total = SW'(count);
    end
  end

  assign top_digit = dig[DW-1 -: 4];
  assign out_free  = !out_valid || dout.ready;

  // Select the character for the output register
  always_comb begin
    case (cmd.sel)
      iaf_pkg::CH_PAD_SPACE: char_next = iaf_pkg::CHAR_SPACE;
      iaf_pkg::CH_PAD_ZERO:  char_next = iaf_pkg::CHAR_ZERO;
      iaf_pkg::CH_SIGN:      char_next = hex_r ? iaf_pkg::CHAR_ZERO : iaf_pkg::CHAR_MINUS;
      iaf_pkg::CH_X:         char_next = iaf_pkg::CHAR_X;
      iaf_pkg::CH_DIGIT:     char_next = iaf_pkg::HEX_CHARS[top_digit];
      default:               char_next = iaf_pkg::CHAR_SPACE;
    endcase
  end

  // Counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      bits      <= '0;
      count     <= '0;
      pad       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        bits  <= opcode ? BW'(0) : BW'(VALUE_BITS);
        count <= CNTW'(NDIG);
      end else if (cmd.conv_step) begin
        bits <= bits - 1'b1;
      end else if (cmd.norm_step ||
                   (cmd.emit && cmd.sel == iaf_pkg::CH_DIGIT)) begin
        count <= count - 1'b1;
      end
      if (cmd.pad_load) begin
        pad <= (width_ext > total) ? WW'(width_ext - total) : '0;
      end else if (cmd.emit && (cmd.sel == iaf_pkg::CH_PAD_SPACE ||
                                cmd.sel == iaf_pkg::CH_PAD_ZERO)) begin
        pad <= pad - 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: settings, digit register and output character
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hex_r   <= opcode;
      neg_r   <= neg_in;
      zpad_r  <= pad_zero;
      width_r <= w_sat;
      bin     <= mag;
      dig     <= opcode ? DW'(mag) : '0;
    end else if (cmd.conv_step) begin
      dig <= {adj[DW-2:0], bin[VALUE_BITS-1]};
      bin <= bin << 1;
    end else if (cmd.norm_step ||
                 (cmd.emit && cmd.sel == iaf_pkg::CH_DIGIT)) begin
      dig <= dig << 4;
    end
    if (cmd.emit) begin
      out_char <= char_next;
      out_last <= cmd.last;
    end
  end

  // Status back to the controller
  always_comb begin
    sts.conv_done  = (bits == '0);
    sts.norm_done  = (top_digit != 4'd0) || (count == CNTW'(1));
    sts.pad_empty  = (pad == '0);
    sts.hex        = hex_r;
    sts.neg        = neg_r;
    sts.zpad       = zpad_r;
    sts.last_digit = (count == CNTW'(1));
    sts.out_free   = out_free;
  end

  assign dout.valid    = out_valid;
  assign dout.char_out = out_char;
  assign dout.last     = out_last;

  // Digits and pad are never emitted past their count
  `IAF_ASSERT_IMPLIES(a_digit_present, clk, rst, cmd.emit && cmd.sel == iaf_pkg::CH_DIGIT, count != '0)
  `IAF_ASSERT_IMPLIES(a_pad_present, clk, rst, cmd.emit && (cmd.sel == iaf_pkg::CH_PAD_SPACE || cmd.sel == iaf_pkg::CH_PAD_ZERO), pad != '0)

endmodule

`default_nettype wire

### hw/rtl/iaf_ctrl.sv
// ----------------------------------------------------------------------------
// iaf_ctrl
// Controller: sequences conversion, normalisation, pad count and the
// character phases of one number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "integer_ascii_formatter_top_macros.svh"

module iaf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire iaf_pkg::sts_t sts,
  output iaf_pkg::cmd_t      cmd
);

  iaf_pkg::state_t state;
  iaf_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iaf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.conv_step = 1'b0;
    cmd.norm_step = 1'b0;
    cmd.pad_load  = 1'b0;
    cmd.emit      = 1'b0;
    cmd.sel       = iaf_pkg::CH_DIGIT;
    cmd.last      = 1'b0;
    case (state)
      iaf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = iaf_pkg::ST_CONV;
        end
      end
      iaf_pkg::ST_CONV: begin
        if (sts.hex || sts.conv_done) begin
          state_next = iaf_pkg::ST_NORM;
        end else begin
          cmd.conv_step = 1'b1;
        end
      end
      iaf_pkg::ST_NORM: begin
        if (sts.norm_done) begin
          state_next = iaf_pkg::ST_PAD;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      iaf_pkg::ST_PAD: begin
        cmd.pad_load = 1'b1;
        state_next   = iaf_pkg::ST_LEAD;
      end
      iaf_pkg::ST_LEAD: begin
        cmd.sel = iaf_pkg::CH_PAD_SPACE;
        if (sts.zpad || sts.pad_empty) begin
          state_next = iaf_pkg::ST_PREFIX;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
        end
      end
      iaf_pkg::ST_PREFIX: begin
        cmd.sel = iaf_pkg::CH_SIGN;
        if (!sts.hex && !sts.neg) begin
          state_next = iaf_pkg::ST_ZEROS;
        end else if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.hex ? iaf_pkg::ST_XMARK : iaf_pkg::ST_ZEROS;
        end
      end
      iaf_pkg::ST_XMARK: begin
        cmd.sel = iaf_pkg::CH_X;
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = iaf_pkg::ST_ZEROS;
        end
      end
      iaf_pkg::ST_ZEROS: begin
        cmd.sel = iaf_pkg::CH_PAD_ZERO;
        if (sts.pad_empty) begin
          state_next = iaf_pkg::ST_DIGITS;
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
        end
      end
      iaf_pkg::ST_DIGITS: begin
        cmd.sel = iaf_pkg::CH_DIGIT;
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = sts.last_digit;
          if (sts.last_digit) begin
            state_next = iaf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = iaf_pkg::ST_IDLE;
      end
    endcase
  end

  // Never overwrite a character still waiting; a transfer starts the work
  `IAF_ASSERT_IMPLIES(a_emit_free, clk, rst, cmd.emit, sts.out_free)
  `IAF_ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && in_ready, state == iaf_pkg::ST_CONV)
  `IAF_ASSERT_IMPLIES(a_last_on_digit, clk, rst, cmd.last, cmd.emit && cmd.sel == iaf_pkg::CH_DIGIT && sts.last_digit)

endmodule

`default_nettype wire

### hw/rtl/integer_ascii_formatter_top.sv
// Sequence: decimal values go through shift-add-3 conversion, hex values skip it;
// normalising shifts out leading zero digits, then the pad count is loaded.
// Throughput: within each character phase, one character per cycle while the sink is ready.
// The next value is taken the cycle after its last character enters the output register.
// Reset: synchronous active-high rst returns the controller to idle and empties the output.
// ----------------------------------------------------------------------------
// integer_ascii_formatter_top
// Formats a value as signed decimal or 0x-prefixed hex ASCII with left pad.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_ascii_formatter_top #(
  parameter int VALUE_BITS = iaf_pkg::VALUE_BITS_DEF,
  parameter int MAX_WIDTH  = iaf_pkg::MAX_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  iaf_in_if.sink    din,
  iaf_out_if.source dout
);

  iaf_pkg::cmd_t cmd;
  iaf_pkg::sts_t sts;
  logic          in_ready;

  // Input handshake is owned by the controller
  assign din.ready = in_ready;

  iaf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  iaf_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_WIDTH  (MAX_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .value       (din.value),
    .opcode      (din.opcode),
    .field_width (din.field_width),
    .pad_zero    (din.pad_zero),
    .cmd         (cmd),
    .sts         (sts),
    .dout        (dout)
  );

endmodule

`default_nettype wire
